// ----- hdl/lcc_pkg.sv -----
// Shared types, constants and step table for the lattice coordinate converter.
package lcc_pkg;

    localparam int COORD_WIDTH = 40;
    localparam int FRAC_BITS   = 24;
    // cofactor width and wide accumulator / divider width
    localparam int CW = 2 * COORD_WIDTH + 1;
    localparam int DW = 3 * COORD_WIDTH + FRAC_BITS + 4;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_F2C  = 2'd1;
    localparam logic [1:0] OP_C2F  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SINGULAR = 2'd1;
    localparam logic [1:0] STAT_SAT      = 2'd2;

    localparam logic [4:0] STEP_COF_END = 5'd18;
    localparam logic [4:0] STEP_DET_END = 5'd21;

    typedef struct packed {
        logic [1:0]                    op;
        logic [1:0]                    row_index;
        logic signed [COORD_WIDTH-1:0] vec_x;
        logic signed [COORD_WIDTH-1:0] vec_y;
        logic signed [COORD_WIDTH-1:0] vec_z;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic signed [COORD_WIDTH-1:0] out_z;
        logic [1:0]                    status;
    } t_out_word;

    typedef enum logic [1:0] {SRC_LAT, SRC_VEC, SRC_COF} t_src;
    typedef enum logic [2:0] {P_NONE, P_COF, P_DET, P_FIN1, P_FIN2} t_post;

    typedef enum logic [2:0] {
        S_IDLE, S_MAC_GO, S_MAC_WAIT, S_POST, S_DET_CHK, S_DIV_WAIT, S_FIT, S_OUT
    } t_state;

    typedef struct packed {
        t_src       a_src;
        logic [3:0] a_idx;
        t_src       b_src;
        logic [3:0] b_idx;
        logic       sub;
        logic       clr;
        t_post      post;
        logic [3:0] p_idx;
    } t_step;

    typedef struct packed {
        logic       capture;
        logic       load_row;
        logic       mac_start;
        t_step      step;
        logic       store_cof;
        logic       store_det;
        logic       shift;
        logic       div_start;
        logic       fit;
        logic [1:0] comp;
        logic       load_out;
        logic       singular;
    } t_cmd;

    typedef struct packed {
        logic mac_busy;
        logic mac_done;
        logic div_busy;
        logic div_done;
        logic det_zero;
        logic out_full;
    } t_stat;

    function automatic logic [1:0] f_div3(input logic [3:0] x);
        return (x >= 4'd6) ? 2'd2 : ((x >= 4'd3) ? 2'd1 : 2'd0);
    endfunction

    function automatic logic [1:0] f_inc3(input logic [1:0] x);
        return (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    function automatic logic [3:0] f_rc(input logic [1:0] r, input logic [1:0] c);
        return {2'b00, r} * 4'd3 + {2'b00, c};
    endfunction

    // Step k of a conversion: one multiply-accumulate and what follows it.
    function automatic t_step f_step(input logic c2f, input logic [4:0] k);
        t_step      s;
        logic [3:0] m;
        logic [1:0] i, j, r1, r2, c1, c2;
        s  = '0;
        m  = '0;
        i  = '0;
        j  = '0;
        r1 = '0;
        r2 = '0;
        c1 = '0;
        c2 = '0;
        if (!c2f) begin
            m = k[3:0];
            j = f_div3(m);
            i = 2'(m - f_rc(2'd0, j) * 4'd3);
            s.a_src = SRC_VEC;
            s.a_idx = {2'b00, i};
            s.b_src = SRC_LAT;
            s.b_idx = f_rc(i, j);
            s.clr   = (i == 2'd0);
            s.post  = (i == 2'd2) ? P_FIN1 : P_NONE;
            s.p_idx = {2'b00, j};
        end else if (k < STEP_COF_END) begin
            m  = k[4:1];
            i  = f_div3(m);
            j  = 2'(m - f_rc(2'd0, i) * 4'd3);
            r1 = f_inc3(i);
            r2 = f_inc3(r1);
            c1 = f_inc3(j);
            c2 = f_inc3(c1);
            s.a_src = SRC_LAT;
            s.b_src = SRC_LAT;
            s.p_idx = m;
            if (!k[0]) begin
                s.a_idx = f_rc(r1, c1);
                s.b_idx = f_rc(r2, c2);
                s.clr   = 1'b1;
                s.post  = P_NONE;
            end else begin
                s.a_idx = f_rc(r1, c2);
                s.b_idx = f_rc(r2, c1);
                s.sub   = 1'b1;
                s.post  = P_COF;
            end
        end else if (k < STEP_DET_END) begin
            j = 2'(k - STEP_COF_END);
            s.a_src = SRC_COF;
            s.a_idx = {2'b00, j};
            s.b_src = SRC_LAT;
            s.b_idx = {2'b00, j};
            s.clr   = (j == 2'd0);
            s.post  = (j == 2'd2) ? P_DET : P_NONE;
        end else begin
            m = 4'(k - STEP_DET_END);
            j = f_div3(m);
            i = 2'(m - f_rc(2'd0, j) * 4'd3);
            s.a_src = SRC_COF;
            s.a_idx = f_rc(j, i);
            s.b_src = SRC_VEC;
            s.b_idx = {2'b00, i};
            s.clr   = (i == 2'd0);
            s.post  = (i == 2'd2) ? P_FIN2 : P_NONE;
            s.p_idx = {2'b00, j};
        end
        return s;
    endfunction

endpackage

// ----- hdl/lcc_datapath.sv -----
// Datapath: lattice and cofactor registers, serial multiplier, divider, saturation.
module lcc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lcc_pkg::t_in_word i_data,
    input  lcc_pkg::t_cmd     i_cmd,
    output lcc_pkg::t_stat    o_stat,
    output logic              o_valid,
    output lcc_pkg::t_out_word o_data,
    input  logic              i_stall
);
    import lcc_pkg::*;

    localparam int MCW = $clog2(COORD_WIDTH);
    localparam int DCW = $clog2(DW);
    localparam logic [MCW-1:0] MCNT_LAST = MCW'(COORD_WIDTH - 1);
    localparam logic [DCW-1:0] DCNT_LAST = DCW'(DW - 1);

    logic signed [COORD_WIDTH-1:0] r_lat [9];
    logic signed [COORD_WIDTH-1:0] r_vec [3];
    logic signed [CW-1:0]          r_cof [9];
    logic signed [COORD_WIDTH-1:0] r_res [3];
    logic signed [DW-1:0]          r_det;
    logic signed [DW-1:0]          r_acc;
    logic [DW-1:0]                 r_ma;
    logic [COORD_WIDTH-1:0]        r_mb;
    logic [MCW-1:0]                r_mcnt;
    logic                          r_msub, r_mbusy, r_mdone;
    logic [DW-1:0]                 r_dn, r_dd, r_dr, r_dq;
    logic [DCW-1:0]                r_dcnt;
    logic                          r_dbusy, r_ddone, r_neg, r_sat, r_oval;
    t_out_word                     r_out;

    logic [DW-1:0]          a_op, term, mterm, rem2, num, fv, shq;
    logic signed [DW-1:0]   acc_sh;
    logic [COORD_WIDTH-1:0] b_op, fval;
    logic [DW-COORD_WIDTH:0] hi;
    logic                   mlast, mneg, ge, fits;
    logic [3:0]             row_base;

    always_comb begin
        unique case (i_cmd.step.a_src)
            SRC_LAT: a_op = {{(DW-COORD_WIDTH){r_lat[i_cmd.step.a_idx][COORD_WIDTH-1]}},
                             r_lat[i_cmd.step.a_idx]};
            SRC_VEC: a_op = {{(DW-COORD_WIDTH){r_vec[i_cmd.step.a_idx[1:0]][COORD_WIDTH-1]}},
                             r_vec[i_cmd.step.a_idx[1:0]]};
            SRC_COF: a_op = {{(DW-CW){r_cof[i_cmd.step.a_idx][CW-1]}},
                             r_cof[i_cmd.step.a_idx]};
            default: a_op = '0;
        endcase
        unique case (i_cmd.step.b_src)
            SRC_LAT: b_op = r_lat[i_cmd.step.b_idx];
            SRC_VEC: b_op = r_vec[i_cmd.step.b_idx[1:0]];
            default: b_op = '0;
        endcase
    end

    // shift-add step; the sign bit of b has negative weight
    assign term  = r_mb[0] ? r_ma : '0;
    assign mlast = (r_mcnt == MCNT_LAST);
    assign mneg  = r_msub ^ mlast;
    assign mterm = mneg ? ~term : term;

    assign rem2 = {r_dr[DW-2:0], r_dn[DW-1]};
    assign ge   = (rem2 >= r_dd);
    assign num  = r_acc <<< FRAC_BITS;
    // arithmetic shift floors; bump negatives with dropped bits toward zero
    assign acc_sh = r_acc >>> FRAC_BITS;
    assign shq    = acc_sh + DW'(r_acc[DW-1] && (r_acc[FRAC_BITS-1:0] != '0));

    assign fv   = r_neg ? -r_dq : r_dq;
    assign hi   = fv[DW-1:COORD_WIDTH-1];
    assign fits = (&hi) || !(|hi);
    assign fval = fits ? fv[COORD_WIDTH-1:0] :
                  (fv[DW-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                            : {1'b0, {(COORD_WIDTH-1){1'b1}}});
    assign row_base = f_rc(i_data.row_index, 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) r_lat[k] <= '0;
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_dbusy <= 1'b0;
            r_ddone <= 1'b0;
            r_oval  <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_mdone <= 1'b0;
            r_ddone <= 1'b0;
            if (i_cmd.load_row && (i_data.row_index != 2'd3)) begin
                r_lat[row_base]        <= i_data.vec_x;
                r_lat[row_base + 4'd1] <= i_data.vec_y;
                r_lat[row_base + 4'd2] <= i_data.vec_z;
            end
            if (i_cmd.capture) r_sat <= 1'b0;
            else if (i_cmd.fit && !fits) r_sat <= 1'b1;
            if (i_cmd.mac_start) begin
                r_mbusy <= 1'b1;
            end else if (r_mbusy && mlast) begin
                r_mbusy <= 1'b0;
                r_mdone <= 1'b1;
            end
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
            end else if (r_dbusy && (r_dcnt == DCNT_LAST)) begin
                r_dbusy <= 1'b0;
                r_ddone <= 1'b1;
            end
            if (i_cmd.load_out) r_oval <= 1'b1;
            else if (r_oval && !i_stall) r_oval <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_vec[0] <= i_data.vec_x;
            r_vec[1] <= i_data.vec_y;
            r_vec[2] <= i_data.vec_z;
        end
        if (i_cmd.mac_start) begin
            r_ma   <= a_op;
            r_mb   <= b_op;
            r_msub <= i_cmd.step.sub;
            r_mcnt <= '0;
            if (i_cmd.step.clr) r_acc <= '0;
        end else if (r_mbusy) begin
            r_acc  <= r_acc + mterm + DW'(mneg);
            r_ma   <= r_ma << 1;
            r_mb   <= r_mb >> 1;
            r_mcnt <= r_mcnt + 1'b1;
        end
        if (i_cmd.store_cof) r_cof[i_cmd.step.p_idx] <= r_acc[CW-1:0];
        if (i_cmd.store_det) r_det <= r_acc;
        if (i_cmd.shift) begin
            r_dq  <= shq;
            r_neg <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dn   <= num[DW-1] ? -num : num;
            r_dd   <= r_det[DW-1] ? -r_det : r_det;
            r_dr   <= '0;
            r_dq   <= '0;
            r_neg  <= num[DW-1] ^ r_det[DW-1];
            r_dcnt <= '0;
        end else if (r_dbusy) begin
            r_dr   <= ge ? rem2 - r_dd : rem2;
            r_dq   <= {r_dq[DW-2:0], ge};
            r_dn   <= r_dn << 1;
            r_dcnt <= r_dcnt + 1'b1;
        end
        if (i_cmd.fit) r_res[i_cmd.comp] <= fval;
        if (i_cmd.load_out) begin
            r_out.out_x  <= i_cmd.singular ? '0 : r_res[0];
            r_out.out_y  <= i_cmd.singular ? '0 : r_res[1];
            r_out.out_z  <= i_cmd.singular ? '0 : r_res[2];
            r_out.status <= i_cmd.singular ? STAT_SINGULAR : (r_sat ? STAT_SAT : STAT_OK);
        end
    end

    assign o_stat.mac_busy = r_mbusy;
    assign o_stat.mac_done = r_mdone;
    assign o_stat.div_busy = r_dbusy;
    assign o_stat.div_done = r_ddone;
    assign o_stat.det_zero = (r_det == '0);
    assign o_stat.out_full = r_oval;
    assign o_valid = r_oval;
    assign o_data  = r_out;

endmodule

// ----- hdl/lcc_controller.sv -----
// Controller: sequences multiply steps, division, saturation and output load.
module lcc_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_op,
    output logic           o_stall,
    output lcc_pkg::t_cmd  o_cmd,
    input  lcc_pkg::t_stat i_stat
);
    import lcc_pkg::*;

    t_state     r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_c2f, r_sing, n_sing;
    t_step      step;

    assign step    = f_step(r_c2f, r_step);
    assign o_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_c2f   <= 1'b0;
            r_sing  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_sing  <= n_sing;
            if (r_state == S_IDLE && i_valid) r_c2f <= (i_op == OP_C2F);
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_sing  = r_sing;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                n_sing = 1'b0;
                if (i_valid && (i_op == OP_F2C || i_op == OP_C2F)) n_state = S_MAC_GO;
            end
            S_MAC_GO:   n_state = S_MAC_WAIT;
            S_MAC_WAIT: if (i_stat.mac_done) n_state = S_POST;
            S_POST: begin
                unique case (step.post)
                    P_FIN1: n_state = S_FIT;
                    P_FIN2: n_state = S_DIV_WAIT;
                    P_DET: begin
                        n_state = S_DET_CHK;
                        n_step  = r_step + 5'd1;
                    end
                    default: begin
                        n_state = S_MAC_GO;
                        n_step  = r_step + 5'd1;
                    end
                endcase
            end
            S_DET_CHK: begin
                if (i_stat.det_zero) begin
                    n_state = S_OUT;
                    n_sing  = 1'b1;
                end else begin
                    n_state = S_MAC_GO;
                end
            end
            S_DIV_WAIT: if (i_stat.div_done) n_state = S_FIT;
            S_FIT: begin
                if (step.p_idx[1:0] == 2'd2) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_MAC_GO;
                    n_step  = r_step + 5'd1;
                end
            end
            S_OUT: if (!i_stat.out_full) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_cmd.step     = step;
        o_cmd.comp     = step.p_idx[1:0];
        o_cmd.singular = r_sing;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture  = i_valid;
                o_cmd.load_row = i_valid && (i_op == OP_LOAD);
            end
            S_MAC_GO: o_cmd.mac_start = 1'b1;
            S_POST: begin
                o_cmd.store_cof = (step.post == P_COF);
                o_cmd.store_det = (step.post == P_DET);
                o_cmd.shift     = (step.post == P_FIN1);
                o_cmd.div_start = (step.post == P_FIN2);
            end
            S_FIT: o_cmd.fit      = 1'b1;
            S_OUT: o_cmd.load_out = !i_stat.out_full;
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_mac_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mac_start |-> !i_stat.mac_busy)
        else $error("multiply started while busy");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> !i_stat.div_busy && !i_stat.mac_busy)
        else $error("divide started while busy");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> !i_stat.out_full)
        else $error("result overwritten");
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.mac_done |-> r_state == S_MAC_WAIT)
        else $error("multiply finished outside wait state");
`endif

endmodule

// ----- hdl/lattice_coordinate_converter.sv -----
// Top level: 3x3 lattice fractional/Cartesian coordinate converter.
// Load word: accepted while idle, no result word.
// Fractional to Cartesian: 9 serial multiply steps to the result.
// Cartesian to fractional: 30 multiply steps plus three restoring divisions;
// a singular lattice ends at the determinant check, before any division.
// One word in flight; next input taken while a result word waits on stall.
// Synchronous active-low reset clears lattice to zero and empties the output.
module lattice_coordinate_converter (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lcc_pkg::t_in_word  i_data,
    output logic               o_stall,
    output logic               o_valid,
    output lcc_pkg::t_out_word o_data,
    input  logic               i_stall
);
    import lcc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing: step table walk, waits on multiplier / divider / output
    lcc_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_op    (i_data.op),
        .o_stall (o_stall),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    // arithmetic and storage, output word register
    lcc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_data  (i_data),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

endmodule

// ----- tb/sv/tb_lattice_coordinate_converter.sv -----
// Testbench for the lattice coordinate converter: directed, random and backpressure tests.
module tb_lattice_coordinate_converter;
    import lcc_pkg::*;

    // op value with no meaning and a row number past the lattice
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] ROW_NONE  = 2'd3;
    // cycles with no word moving on either side before the run is called hung
    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 4000;

    // exact intermediate values: products of three coordinates plus the scale fit easily
    typedef logic signed [255:0] t_wide;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    t_in_word  i_data = '0;
    logic      o_stall;
    logic      o_valid;
    t_out_word o_data;
    logic      i_stall = 1'b0;

    lattice_coordinate_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always #5 i_clk = ~i_clk;

    // our own copy of the cell matrix, row-major, updated when a load word is taken
    logic signed [COORD_WIDTH-1:0] cell_mat [9];
    t_out_word conversions_due [$];

    int errors      = 0;
    int checked     = 0;
    int n_sat       = 0;
    int n_singular  = 0;
    int n_loads     = 0;
    int idle_cycles = 0;

    // sender burst shaping and receiver stall controls
    int  burst_left = 0;
    int  gap_max    = 8;
    bit  rx_random  = 1'b0;
    bit  hold_req   = 1'b0;
    int  hold_cnt   = 0;

    function automatic t_wide widen(input logic signed [COORD_WIDTH-1:0] x);
        return {{(256-COORD_WIDTH){x[COORD_WIDTH-1]}}, x};
    endfunction

    function automatic t_wide cell_at(input int r, input int c);
        return widen(cell_mat[(r % 3) * 3 + (c % 3)]);
    endfunction

    // signed cofactor of entry (r,c) of the cell matrix
    function automatic t_wide cofactor_of(input int r, input int c);
        return cell_at(r + 1, c + 1) * cell_at(r + 2, c + 2)
             - cell_at(r + 1, c + 2) * cell_at(r + 2, c + 1);
    endfunction

    // clamp to the coordinate width, raising the saturation flag when it clips
    function automatic logic [COORD_WIDTH-1:0] clamp_coord(input t_wide v, inout bit sat);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (COORD_WIDTH - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            sat = 1'b1;
            return hi[COORD_WIDTH-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    // expected output word of a conversion against the current cell matrix
    function automatic t_out_word convert_coords(input t_in_word w);
        t_out_word r;
        t_wide     v [3];
        t_wide     acc;
        t_wide     det;
        logic [COORD_WIDTH-1:0] res [3];
        bit        sat;
        r   = '0;
        sat = 1'b0;
        v[0] = widen(w.vec_x);
        v[1] = widen(w.vec_y);
        v[2] = widen(w.vec_z);
        if (w.op == OP_F2C) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += v[i] * cell_at(i, j);
                // signed divide truncates toward zero, as the hardware must
                res[j] = clamp_coord(acc / (t_wide'(1) <<< FRAC_BITS), sat);
            end
        end else begin
            det = 0;
            for (int j = 0; j < 3; j++) det += cell_at(0, j) * cofactor_of(0, j);
            if (det == 0) begin
                r.status = STAT_SINGULAR;
                return r;
            end
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int i = 0; i < 3; i++) acc += v[i] * cofactor_of(j, i);
                res[j] = clamp_coord((acc <<< FRAC_BITS) / det, sat);
            end
        end
        r.out_x  = res[0];
        r.out_y  = res[1];
        r.out_z  = res[2];
        r.status = sat ? STAT_SAT : STAT_OK;
        return r;
    endfunction

    // drive one word from a falling edge and hold it until the block takes it
    task automatic send_word(input t_in_word w);
        i_valid = 1'b1;
        i_data  = w;
        do @(posedge i_clk); while (o_stall);
        if (w.op == OP_LOAD) begin
            if (w.row_index != ROW_NONE) begin
                cell_mat[w.row_index * 3 + 0] = w.vec_x;
                cell_mat[w.row_index * 3 + 1] = w.vec_y;
                cell_mat[w.row_index * 3 + 2] = w.vec_z;
                n_loads++;
            end
        end else if (w.op != OP_UNUSED) begin
            conversions_due.push_back(convert_coords(w));
        end
        @(negedge i_clk);
        // bursts of random length, random gaps between them
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            i_valid = 1'b0;
            repeat ($urandom_range(0, gap_max)) @(negedge i_clk);
            burst_left = $urandom_range(0, 6);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [1:0] row,
                           input logic [COORD_WIDTH-1:0] x, input logic [COORD_WIDTH-1:0] y,
                           input logic [COORD_WIDTH-1:0] z);
        t_in_word w;
        w.op = op;
        w.row_index = row;
        w.vec_x = x;
        w.vec_y = y;
        w.vec_z = z;
        send_word(w);
    endtask

    // wait for every outstanding result, then a few cycles for a trailing load
    task automatic drain;
        i_valid = 1'b0;
        while (conversions_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // coordinate of mixed magnitude: full range, extremes, or a few lattice units
    function automatic logic [COORD_WIDTH-1:0] rand_coord();
        logic [COORD_WIDTH-1:0] x;
        case ($urandom_range(0, 9))
            0, 1: x = COORD_WIDTH'({$urandom, $urandom});
            2: x = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            3: x = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            default: x = COORD_WIDTH'($urandom_range(0, 32'h0FFF_FFFF)) - 40'h0800_0000;
        endcase
        return x;
    endfunction

    localparam logic [COORD_WIDTH-1:0] ONE  = 40'h00_0100_0000;
    localparam logic [COORD_WIDTH-1:0] CMAX = 40'h7F_FFFF_FFFF;
    localparam logic [COORD_WIDTH-1:0] CMIN = 40'h80_0000_0000;

    // zero lattice after reset: singular inverse, zero forward result
    task automatic test_reset_lattice;
        send_op(OP_C2F, 2'd0, ONE, ONE, ONE);
        send_op(OP_F2C, 2'd0, CMAX, CMIN, ONE);
        drain();
    endtask

    // identity and extreme lattices, extreme vectors, ignored words
    task automatic test_directed;
        send_op(OP_LOAD, 2'd0, ONE, '0, '0);
        send_op(OP_LOAD, 2'd1, '0, ONE, '0);
        send_op(OP_LOAD, 2'd2, '0, '0, ONE);
        send_op(OP_F2C, 2'd0, CMAX, CMIN, 40'hFF_FFFF_FFFF);
        send_op(OP_C2F, 2'd3, CMIN, CMAX, 40'h00_0000_0001);
        // ignored: undefined op and out-of-range row leave the identity intact
        send_op(OP_UNUSED, 2'd0, CMAX, CMAX, CMAX);
        send_op(OP_LOAD, ROW_NONE, CMIN, CMIN, CMIN);
        send_op(OP_C2F, 2'd0, ONE, 40'hFF_FF00_0000, 40'h00_0080_0000);
        // huge lattice entries force the forward result to saturate
        send_op(OP_LOAD, 2'd0, CMAX, CMIN, CMAX);
        send_op(OP_F2C, 2'd0, CMAX, '0, '0);
        send_op(OP_F2C, 2'd0, CMIN, '0, '0);
        // tiny lattice makes the inverse saturate
        send_op(OP_LOAD, 2'd0, 40'd1, '0, '0);
        send_op(OP_LOAD, 2'd1, '0, 40'd1, '0);
        send_op(OP_LOAD, 2'd2, '0, '0, 40'd1);
        send_op(OP_C2F, 2'd0, CMAX, CMIN, ONE);
        // two equal rows: singular
        send_op(OP_LOAD, 2'd2, '0, 40'd1, '0);
        send_op(OP_C2F, 2'd0, ONE, ONE, ONE);
        drain();
    endtask

    // mostly well-formed: a fresh lattice then a run of conversions; some noise
    task automatic test_random(input int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                for (int r = 0; r < 3; r++) begin
                    send_op(OP_LOAD, 2'(r), rand_coord(), rand_coord(), rand_coord());
                end
                // now and then copy a row to make the lattice singular
                if ($urandom_range(0, 7) == 0) begin
                    k = $urandom_range(1, 2);
                    send_op(OP_LOAD, 2'(k), cell_mat[0], cell_mat[1], cell_mat[2]);
                    sent++;
                end
                sent += 3;
            end
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0: send_op(OP_UNUSED, 2'($urandom), rand_coord(), rand_coord(),
                               rand_coord());
                    1: send_op(OP_LOAD, 2'($urandom_range(0, 3)), rand_coord(), rand_coord(),
                               rand_coord());
                    2, 3, 4, 5: send_op(OP_F2C, 2'($urandom), rand_coord(), rand_coord(),
                                        rand_coord());
                    default: send_op(OP_C2F, 2'($urandom), rand_coord(), rand_coord(),
                                     rand_coord());
                endcase
                sent++;
            end
            if ($urandom_range(0, 15) == 0) drain();
        end
        drain();
    endtask

    // receiver holds off while words keep coming, so the input must stall
    task automatic test_backpressure;
        hold_req = 1'b1;
        gap_max  = 0;
        repeat (6) send_op(OP_F2C, 2'd0, rand_coord(), rand_coord(), rand_coord());
        send_op(OP_C2F, 2'd0, rand_coord(), rand_coord(), rand_coord());
        drain();
        gap_max = 8;
    endtask

    // receiver stall pattern; a long hold counted here when asked for
    always @(negedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_stall = 1'b1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = LONG_HOLD;
            i_stall  = 1'b1;
        end else begin
            i_stall = rx_random && ($urandom_range(0, 3) == 0);
        end
    end

    // result checker: compare each accepted word against the oldest prediction
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (conversions_due.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, o_data);
                errors++;
            end else begin
                want = conversions_due.pop_front();
                checked++;
                if (want.status == STAT_SAT) n_sat++;
                if (want.status == STAT_SINGULAR) n_singular++;
                if (o_data.out_x !== want.out_x)
                    $display("%0t: out_x expected %h got %h", $time, want.out_x, o_data.out_x);
                if (o_data.out_y !== want.out_y)
                    $display("%0t: out_y expected %h got %h", $time, want.out_y, o_data.out_y);
                if (o_data.out_z !== want.out_z)
                    $display("%0t: out_z expected %h got %h", $time, want.out_z, o_data.out_z);
                if (o_data.status !== want.status)
                    $display("%0t: status expected %0d got %0d", $time, want.status,
                             o_data.status);
                if (o_data !== want) errors++;
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 9; k++) cell_mat[k] = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_lattice();
        test_directed();
        rx_random = 1'b1;
        test_random(400);
        test_backpressure();
        rx_random = 1'b0;
        test_random(200);
        rx_random = 1'b1;
        test_random(200);
        if (conversions_due.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, conversions_due.size());
            errors++;
        end
        $display("Checked %0d conversions (%0d saturated, %0d singular) after %0d row loads;",
                 checked, n_sat, n_singular, n_loads);
        $display("%0d mismatching result words.", errors);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
